// ----- design/assert_macros.svh -----
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/usd_pkg.sv -----
package usd_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int CP_W   = 21;
    localparam int BITS_W = 7;
    localparam int KIND_W = 3;

    // byte classes decided by the front end
    localparam logic [KIND_W-1:0] KIND_ASCII   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LEAD2   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LEAD3   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LEAD4   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CONT    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_INVALID = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            truncated;
        logic            invalid_lead;
        logic            last_of_string;
    } out_item_t;

    // classified byte: class, payload bits already masked, end mark
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BITS_W-1:0] bits;
        logic              eos;
    } q_item_t;

    typedef struct packed {
        logic pending;
        logic seq_open;
    } back_status_t;

endpackage

// ----- design/usd_front.sv -----
module usd_front
    import usd_pkg::*;
(
    input  logic     byte_valid,
    input  in_item_t byte_item,
    input  logic     q_full,
    output logic     byte_stall,
    output logic     q_push,
    output q_item_t  q_wr_item
);

    logic [7:0] b;

    assign b          = byte_item.in_byte;
    assign byte_stall = q_full;
    assign q_push     = byte_valid && !q_full;

    always_comb
    begin
        q_wr_item.eos = byte_item.end_of_string;
        if (b[7] == 1'b0)
        begin
            q_wr_item.kind = KIND_ASCII;
            q_wr_item.bits = b[6:0];
        end
        else if ((b & 8'hC0) == 8'h80)
        begin
            q_wr_item.kind = KIND_CONT;
            q_wr_item.bits = {1'b0, b[5:0]};
        end
        else if ((b & 8'hE0) == 8'hC0)
        begin
            q_wr_item.kind = KIND_LEAD2;
            q_wr_item.bits = {2'b00, b[4:0]};
        end
        else if ((b & 8'hF0) == 8'hE0)
        begin
            q_wr_item.kind = KIND_LEAD3;
            q_wr_item.bits = {3'b000, b[3:0]};
        end
        else if ((b & 8'hF8) == 8'hF0)
        begin
            q_wr_item.kind = KIND_LEAD4;
            q_wr_item.bits = {4'b0000, b[2:0]};
        end
        else
        begin
            q_wr_item.kind = KIND_INVALID;
            q_wr_item.bits = '0;
        end
    end

endmodule

// ----- design/usd_queue.sv -----
module usd_queue
    import usd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t wr_item,
    input  logic    pop,
    output q_item_t rd_item,
    output logic    full,
    output logic    not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_item_t         entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- design/usd_back.sv -----
module usd_back
    import usd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_item_t      q_item,
    input  logic         q_avail,
    output logic         q_pop,
    output logic         cp_valid,
    input  logic         cp_stall,
    output out_item_t    cp_item,
    output back_status_t status
);

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      rem_reg, rem_next;
    logic            out_valid_reg;
    out_item_t       out_reg;
    logic            pend_valid_reg;
    out_item_t       pend_reg;

    logic            can_load;
    out_item_t       r0, r1, lead_res;
    logic            has0, has1, lead_has, lead_on;
    logic [CP_W-1:0] lead_acc, shifted;
    logic [1:0]      lead_rem, rem_dec;

    assign can_load = !out_valid_reg || !cp_stall;
    assign q_pop    = q_avail && !pend_valid_reg && can_load;
    assign cp_valid = out_valid_reg;
    assign cp_item  = out_reg;
    assign status.pending  = pend_valid_reg;
    assign status.seq_open = (rem_reg != 2'd0);

    assign shifted = {acc_reg[CP_W-7:0], q_item.bits[5:0]};
    assign rem_dec = rem_reg - 2'd1;

    // byte taken as a lead, with no sequence open or after an interrupted one
    always_comb
    begin
        lead_res = '0;
        lead_has = 1'b1;
        lead_acc = '0;
        lead_rem = 2'd0;
        unique case (q_item.kind) inside
            KIND_ASCII:
            begin
                lead_res.code_point     = CP_W'(q_item.bits);
                lead_res.last_of_string = q_item.eos;
            end
            KIND_LEAD2, KIND_LEAD3, KIND_LEAD4:
            begin
                if (q_item.eos)
                begin
                    lead_res.code_point     = CP_W'(q_item.bits);
                    lead_res.truncated      = 1'b1;
                    lead_res.last_of_string = 1'b1;
                end
                else
                begin
                    lead_has = 1'b0;
                    lead_acc = CP_W'(q_item.bits);
                    if (q_item.kind == KIND_LEAD2)
                    begin
                        lead_rem = 2'd1;
                    end
                    else if (q_item.kind == KIND_LEAD3)
                    begin
                        lead_rem = 2'd2;
                    end
                    else
                    begin
                        lead_rem = 2'd3;
                    end
                end
            end
            default:
            begin
                // stray continuation or bad lead
                lead_res.invalid_lead   = 1'b1;
                lead_res.last_of_string = q_item.eos;
            end
        endcase
    end

    always_comb
    begin
        r0       = '0;
        r1       = '0;
        has0     = 1'b0;
        has1     = 1'b0;
        acc_next = acc_reg;
        rem_next = rem_reg;
        lead_on  = 1'b0;
        if (rem_reg != 2'd0)
        begin
            if (q_item.kind == KIND_CONT)
            begin
                if (rem_dec == 2'd0)
                begin
                    has0              = 1'b1;
                    r0.code_point     = shifted;
                    r0.last_of_string = q_item.eos;
                    acc_next          = '0;
                    rem_next          = 2'd0;
                end
                else if (q_item.eos)
                begin
                    has0              = 1'b1;
                    r0.code_point     = shifted;
                    r0.truncated      = 1'b1;
                    r0.last_of_string = 1'b1;
                    acc_next          = '0;
                    rem_next          = 2'd0;
                end
                else
                begin
                    acc_next = shifted;
                    rem_next = rem_dec;
                end
            end
            else
            begin
                // interrupted: flush partial value, then decode byte as lead
                has0          = 1'b1;
                r0.code_point = acc_reg;
                r0.truncated  = 1'b1;
                lead_on       = 1'b1;
                has1          = lead_has;
                r1            = lead_res;
            end
        end
        else
        begin
            lead_on = 1'b1;
            has0    = lead_has;
            r0      = lead_res;
        end
        if (lead_on)
        begin
            acc_next = lead_acc;
            rem_next = lead_rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            rem_reg        <= 2'd0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
            end
            if (pend_valid_reg && can_load)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (q_pop && has0)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= has1;
            end
            else if (can_load)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_reg && can_load)
        begin
            out_reg <= pend_reg;
        end
        else if (q_pop && has0)
        begin
            out_reg  <= r0;
            pend_reg <= r1;
        end
    end

endmodule

// ----- design/utf8_stream_decoder_top.sv -----
// channel   dir  handshake                  payload
// byte      in   byte_valid / byte_stall    byte_item  (in_item_t)
// cp        out  cp_valid / cp_stall        cp_item    (out_item_t)
//
// one byte per cycle while the queue has room; a byte that yields two code points holds
// the back end while the second one drains through the output register
// an accepted byte is registered in the queue, its code point in the output register
// the front takes bytes while the classified-byte queue has room
// reset clears queue pointers, decoder state and output valids, asynchronously
`include "assert_macros.svh"

module utf8_stream_decoder_top
    import usd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      cp_valid,
    input  logic      cp_stall,
    output out_item_t cp_item
);

    q_item_t      q_wr_item, q_rd_item;
    logic         q_push, q_pop, q_full, q_not_empty;
    back_status_t back_status;

    usd_front u_front (
        .byte_valid (byte_valid),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .byte_stall (byte_stall),
        .q_push     (q_push),
        .q_wr_item  (q_wr_item)
    );

    usd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_item   (q_wr_item),
        .pop       (q_pop),
        .rd_item   (q_rd_item),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    usd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (q_rd_item),
        .q_avail  (q_not_empty),
        .q_pop    (q_pop),
        .cp_valid (cp_valid),
        .cp_stall (cp_stall),
        .cp_item  (cp_item),
        .status   (back_status)
    );

    `ASSERT_IMPLY(a_pend_has_out, clk, rst_n, back_status.pending, cp_valid, "second item without first")
    `ASSERT_ALWAYS(a_no_pop_pend, clk, rst_n, !(back_status.pending && q_pop), "pop while pending")
    `ASSERT_IMPLY(a_pend_from_pop, clk, rst_n, $rose(back_status.pending), $past(q_pop), "pending w/o pop")
    `ASSERT_IMPLY(a_open_no_out_flag, clk, rst_n, back_status.seq_open && q_pop && q_rd_item.kind == KIND_ASCII, !(back_status.pending && !cp_valid), "ascii interrupt")

endmodule
